>>> rtl/core/ghpool_pkg.sv
// Types, codes and constants of the generational handle pool.
package ghpool_pkg;

    localparam int GEN_W            = 32;
    localparam int IDX_FIELD_W      = 16;
    localparam int COUNT_FIELD_W    = 17;
    localparam int DEFAULT_CAPACITY = 256;
    localparam int IN_TDATA_W       = 56;
    localparam int OUT_TDATA_W      = 88;
    localparam int CFG_INDEX_W      = 1;

    localparam logic [GEN_W-1:0] GEN_MAX         = '1;
    localparam logic [GEN_W-1:0] RESET_START_GEN = GEN_W'(1);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_START_GEN = 1'b0,
        REG_LOW_FIRST = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        CMD_INIT  = 3'd0,
        CMD_ALLOC = 3'd1,
        CMD_FREE  = 3'd2,
        CMD_CHECK = 3'd3,
        CMD_CLEAR = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NO_FREE = 3'd1,
        ST_RANGE   = 3'd2,
        ST_NOT_OCC = 3'd3,
        ST_GEN     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        SLOT_FREE     = 2'd0,
        SLOT_OCCUPIED = 2'd1,
        SLOT_RETIRED  = 2'd2
    } slot_state_t;

    typedef struct packed {
        slot_state_t      state;
        logic [GEN_W-1:0] gen;
    } slot_word_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_INIT,
        FSM_ALLOC_STK,
        FSM_ALLOC_SLOT,
        FSM_HCHK,
        FSM_CLEAR,
        FSM_RESP
    } fsm_t;

endpackage

>>> rtl/core/generational_handle_pool_unit.sv
// Generational handle pool: slot memory, free-index stack memory and command sequencer.
//
// Commands arrive as beats on the s_axis group (command, handle index, handle
// generation); each command returns exactly one result beat on m_axis (status,
// allocated handle, retired flag, live and free counts). Commands are handled
// one at a time. Slot generation/state sit in one synchronous memory, the free
// index stack in another, both read through a registered output; the sequencer
// reads, updates and writes back.
// Steps from accept to result beat:
//   alloc: stack read, slot read, write back; free/check: slot read;
//   out-of-range handle, empty-stack alloc, unknown command: result directly;
//   init: one slot written per cycle;
//   clear: one slot read per cycle, written back in the following cycle.
// The result register lets a finished result wait while m_tready is low; the
// sequencer holds its last step until the register frees, and s_tready stays
// low meanwhile. After reset the pool runs an init pass (generation 1, highest
// index allocated first) with s_tready low; cfg writes are taken at any time.
module generational_handle_pool_unit
    import ghpool_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [GEN_W-1:0]       cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [2:0] command, [18:3] handle_index, [50:19] handle_generation
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [2:0] status, [18:3] out_index, [50:19] out_generation, [51] slot_retired,
    // [68:52] live_slots, [85:69] free_slots
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_CNT  = CW'(CAPACITY);
    localparam logic [CW-1:0] LAST_IDX = CW'(CAPACITY - 1);
    localparam logic [IDX_FIELD_W:0] CAP_EXT = (IDX_FIELD_W+1)'(CAPACITY);

    // configuration
    logic [GEN_W-1:0] start_gen_reg;
    logic             low_first_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_gen_reg <= RESET_START_GEN;
            low_first_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_START_GEN: start_gen_reg <= cfg_data;
                REG_LOW_FIRST: low_first_reg <= cfg_data[0];
                default:       start_gen_reg <= start_gen_reg;
            endcase
        end
    end

    // memories
    slot_word_t       slot_mem [CAPACITY];
    logic [IW-1:0]    stack_mem [CAPACITY];
    slot_word_t       slot_rdata;
    logic [IW-1:0]    stack_rdata;
    logic             slot_we;
    logic [IW-1:0]    slot_waddr;
    slot_word_t       slot_wdata;
    logic [IW-1:0]    slot_raddr;
    logic             stack_we;
    logic [IW-1:0]    stack_waddr;
    logic [IW-1:0]    stack_wdata;
    logic [IW-1:0]    stack_raddr;

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        slot_rdata <= slot_mem[slot_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[stack_waddr] <= stack_wdata;
        end
        stack_rdata <= stack_mem[stack_raddr];
    end

    // sequencer state
    fsm_t                   state_reg, state_next;
    logic                   boot_reg, boot_next;
    logic [CW-1:0]          sweep_reg, sweep_next;
    logic                   p_valid_reg, p_valid_next;
    logic [IW-1:0]          p_k_reg, p_k_next;
    logic [CW-1:0]          depth_reg, depth_next;
    logic [CW-1:0]          live_reg, live_next;
    cmd_t                   cmd_reg, cmd_next;
    logic [IDX_FIELD_W-1:0] idx_reg, idx_next;
    logic [GEN_W-1:0]       hgen_reg, hgen_next;
    status_t                status_reg, status_next;
    logic [IW-1:0]          oidx_reg, oidx_next;
    logic [GEN_W-1:0]       ogen_reg, ogen_next;
    logic                   retired_reg, retired_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic             accept;
    logic             out_free;
    logic             in_range;
    logic             sweep_issue;
    logic             init_last;
    logic [CW-1:0]    stack_top;
    logic [GEN_W-1:0] init_gen;
    cmd_t             in_cmd;

    assign in_cmd      = cmd_t'(s_tdata[2:0]);
    assign s_tready    = (state_reg == FSM_IDLE);
    assign accept      = s_tvalid && s_tready;
    assign out_free    = !m_tvalid_reg || m_tready;
    assign in_range    = {1'b0, s_tdata[18:3]} < CAP_EXT;
    assign sweep_issue = (sweep_reg != CAP_CNT);
    assign init_last   = (sweep_reg == LAST_IDX);
    assign stack_top   = depth_reg - 1'b1;
    assign init_gen    = boot_reg ? RESET_START_GEN : start_gen_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE:
            begin
                if (accept)
                begin
                    case (in_cmd)
                        CMD_INIT:  state_next = FSM_INIT;
                        CMD_ALLOC: state_next = (depth_reg == '0) ? FSM_RESP
                                                                  : FSM_ALLOC_STK;
                        CMD_FREE, CMD_CHECK:
                                   state_next = in_range ? FSM_HCHK : FSM_RESP;
                        CMD_CLEAR: state_next = FSM_CLEAR;
                        default:   state_next = FSM_RESP;
                    endcase
                end
            end
            FSM_INIT:
            begin
                if (init_last)
                begin
                    state_next = boot_reg ? FSM_IDLE : FSM_RESP;
                end
            end
            FSM_ALLOC_STK:  state_next = FSM_ALLOC_SLOT;
            FSM_ALLOC_SLOT: state_next = FSM_RESP;
            FSM_HCHK:       state_next = FSM_RESP;
            FSM_CLEAR:
            begin
                if (!sweep_issue && !p_valid_reg)
                begin
                    state_next = FSM_RESP;
                end
            end
            FSM_RESP:
            begin
                if (out_free)
                begin
                    state_next = FSM_IDLE;
                end
            end
            default: state_next = FSM_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        boot_next     = boot_reg;
        sweep_next    = sweep_reg;
        p_valid_next  = 1'b0;
        p_k_next      = p_k_reg;
        depth_next    = depth_reg;
        live_next     = live_reg;
        cmd_next      = cmd_reg;
        idx_next      = idx_reg;
        hgen_next     = hgen_reg;
        status_next   = status_reg;
        oidx_next     = oidx_reg;
        ogen_next     = ogen_reg;
        retired_next  = retired_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;

        slot_we     = 1'b0;
        slot_waddr  = '0;
        slot_wdata  = '{state: SLOT_FREE, gen: '0};
        slot_raddr  = '0;
        stack_we    = 1'b0;
        stack_waddr = '0;
        stack_wdata = '0;
        stack_raddr = stack_top[IW-1:0];

        unique case (state_reg)
            FSM_IDLE:
            begin
                slot_raddr = s_tdata[3 +: IW];
                if (accept)
                begin
                    cmd_next     = in_cmd;
                    idx_next     = s_tdata[18:3];
                    hgen_next    = s_tdata[50:19];
                    status_next  = ST_OK;
                    oidx_next    = '0;
                    ogen_next    = '0;
                    retired_next = 1'b0;
                    sweep_next   = '0;
                    case (in_cmd)
                        CMD_ALLOC:
                        begin
                            if (depth_reg == '0)
                            begin
                                status_next = ST_NO_FREE;
                            end
                        end
                        CMD_FREE, CMD_CHECK:
                        begin
                            if (!in_range)
                            begin
                                status_next = ST_RANGE;
                            end
                        end
                        CMD_CLEAR: depth_next = '0;
                        default:   status_next = ST_OK;
                    endcase
                end
            end
            FSM_INIT:
            begin
                slot_we     = 1'b1;
                slot_waddr  = sweep_reg[IW-1:0];
                slot_wdata  = '{state: SLOT_FREE, gen: init_gen};
                stack_we    = 1'b1;
                stack_waddr = sweep_reg[IW-1:0];
                stack_wdata = (low_first_reg && !boot_reg) ? LAST_IDX[IW-1:0] - sweep_reg[IW-1:0]
                                                           : sweep_reg[IW-1:0];
                sweep_next  = sweep_reg + 1'b1;
                if (init_last)
                begin
                    depth_next = CAP_CNT;
                    live_next  = '0;
                    boot_next  = 1'b0;
                end
            end
            FSM_ALLOC_STK:
            begin
                slot_raddr = stack_rdata;
                p_k_next   = stack_rdata;
            end
            FSM_ALLOC_SLOT:
            begin
                slot_we    = 1'b1;
                slot_waddr = p_k_reg;
                slot_wdata = '{state: SLOT_OCCUPIED, gen: slot_rdata.gen};
                depth_next = depth_reg - 1'b1;
                live_next  = live_reg + 1'b1;
                oidx_next  = p_k_reg;
                ogen_next  = slot_rdata.gen;
            end
            FSM_HCHK:
            begin
                if (slot_rdata.state != SLOT_OCCUPIED)
                begin
                    status_next = ST_NOT_OCC;
                end
                else if (slot_rdata.gen != hgen_reg)
                begin
                    status_next = ST_GEN;
                end
                else if (cmd_reg == CMD_FREE)
                begin
                    slot_we    = 1'b1;
                    slot_waddr = idx_reg[IW-1:0];
                    if (slot_rdata.gen == GEN_MAX)
                    begin
                        slot_wdata   = '{state: SLOT_RETIRED, gen: slot_rdata.gen};
                        retired_next = 1'b1;
                    end
                    else
                    begin
                        slot_wdata = '{state: SLOT_FREE, gen: slot_rdata.gen + 1'b1};
                        if (depth_reg != CAP_CNT)
                        begin
                            stack_we    = 1'b1;
                            stack_waddr = depth_reg[IW-1:0];
                            stack_wdata = idx_reg[IW-1:0];
                            depth_next  = depth_reg + 1'b1;
                        end
                    end
                    if (live_reg != '0)
                    begin
                        live_next = live_reg - 1'b1;
                    end
                end
            end
            FSM_CLEAR:
            begin
                // read slot k while slot k-1 is updated and, unless retired, pushed
                slot_raddr   = sweep_reg[IW-1:0];
                p_valid_next = sweep_issue;
                p_k_next     = sweep_reg[IW-1:0];
                if (sweep_issue)
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
                if (p_valid_reg)
                begin
                    slot_waddr  = p_k_reg;
                    stack_waddr = depth_reg[IW-1:0];
                    stack_wdata = p_k_reg;
                    case (slot_rdata.state)
                        SLOT_OCCUPIED:
                        begin
                            slot_we = 1'b1;
                            if (slot_rdata.gen == GEN_MAX)
                            begin
                                slot_wdata = '{state: SLOT_RETIRED, gen: slot_rdata.gen};
                            end
                            else
                            begin
                                slot_wdata = '{state: SLOT_FREE, gen: slot_rdata.gen + 1'b1};
                                stack_we   = 1'b1;
                                depth_next = depth_reg + 1'b1;
                            end
                        end
                        SLOT_FREE:
                        begin
                            stack_we   = 1'b1;
                            depth_next = depth_reg + 1'b1;
                        end
                        default: slot_we = 1'b0;
                    endcase
                end
                if (!sweep_issue && !p_valid_reg)
                begin
                    live_next = '0;
                end
            end
            FSM_RESP:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tdata_next[2:0]   = status_reg;
                    m_tdata_next[18:3]  = IDX_FIELD_W'(oidx_reg);
                    m_tdata_next[50:19] = ogen_reg;
                    m_tdata_next[51]    = retired_reg;
                    m_tdata_next[68:52] = COUNT_FIELD_W'(live_reg);
                    m_tdata_next[85:69] = COUNT_FIELD_W'(depth_reg);
                end
            end
            default: m_tdata_next = m_tdata_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= FSM_INIT;
            boot_reg     <= 1'b1;
            sweep_reg    <= '0;
            p_valid_reg  <= 1'b0;
            depth_reg    <= CAP_CNT;
            live_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            boot_reg     <= boot_next;
            sweep_reg    <= sweep_next;
            p_valid_reg  <= p_valid_next;
            depth_reg    <= depth_next;
            live_reg     <= live_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_k_reg     <= p_k_next;
        cmd_reg     <= cmd_next;
        idx_reg     <= idx_next;
        hgen_reg    <= hgen_next;
        status_reg  <= status_next;
        oidx_reg    <= oidx_next;
        ogen_reg    <= ogen_next;
        retired_reg <= retired_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // occupied plus stacked never exceeds the pool between commands
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FSM_IDLE) |-> ({1'b0, depth_reg} + {1'b0, live_reg}) <= {1'b0, CAP_CNT})
        else $error("live plus free count exceeds capacity");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FSM_IDLE) |-> (!slot_we && !stack_we))
        else $error("memory write while idle");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[2:0] == ST_NO_FREE) |-> (m_tdata[85:69] == '0))
        else $error("no-free status with a nonempty stack");

    a_retire_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[51]) |-> (m_tdata[2:0] == ST_OK))
        else $error("slot retired on a failed command");

    a_pipe_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        p_valid_reg |-> (state_reg == FSM_CLEAR))
        else $error("clear pipeline active outside clear");

endmodule
